// File: hw/rtl/pwrseq_pkg.sv
// Shared types, codes and reset constants for the board power sequencer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pwrseq_pkg;

    localparam int unsigned TICK_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CODE_W = 4;

    // Configuration register reset values
    localparam logic [CFG_W-1:0] INIT_TIMEOUT_RST       = 16'd500;
    localparam logic [CFG_W-1:0] RAMP_TIMEOUT_RST       = 16'd3000;
    localparam logic [CFG_W-1:0] POWERFAIL_DELAY_RST    = 16'd3000;
    localparam logic [CFG_W-1:0] ERROR_DELAY_RST        = 16'd3000;
    localparam logic [CFG_W-1:0] READ_INTERVAL_RAMP_RST = 16'd10;
    localparam logic [CFG_W-1:0] READ_INTERVAL_RUN_RST  = 16'd100;

    typedef enum logic [2:0] {
        CFG_INIT_TIMEOUT       = 3'd0,
        CFG_RAMP_TIMEOUT       = 3'd1,
        CFG_POWERFAIL_DELAY    = 3'd2,
        CFG_ERROR_DELAY        = 3'd3,
        CFG_READ_INTERVAL_RAMP = 3'd4,
        CFG_READ_INTERVAL_RUN  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SW_KEEP = 2'd0,
        SW_ON   = 2'd1,
        SW_OFF  = 2'd2
    } t_switch;

    localparam logic [1:0] THERMAL_COOL     = 2'd0;
    localparam logic [1:0] THERMAL_SHUTDOWN = 2'd2;

    typedef enum logic [9:0] {
        ST_INIT      = 10'b00_0000_0001,
        ST_WAITINPUT = 10'b00_0000_0010,
        ST_STANDBY   = 10'b00_0000_0100,
        ST_RAMP      = 10'b00_0000_1000,
        ST_RUN       = 10'b00_0001_0000,
        ST_OVERHEAT  = 10'b00_0010_0000,
        ST_PWRFAIL   = 10'b00_0100_0000,
        ST_FAILWAIT  = 10'b00_1000_0000,
        ST_ERROR     = 10'b01_0000_0000,
        ST_OFF       = 10'b10_0000_0000
    } t_state;

    // Numeric state codes as seen on the result channel
    localparam logic [CODE_W-1:0] CODE_INIT      = 4'd0;
    localparam logic [CODE_W-1:0] CODE_WAITINPUT = 4'd1;
    localparam logic [CODE_W-1:0] CODE_STANDBY   = 4'd2;
    localparam logic [CODE_W-1:0] CODE_RAMP      = 4'd3;
    localparam logic [CODE_W-1:0] CODE_RUN       = 4'd4;
    localparam logic [CODE_W-1:0] CODE_OVERHEAT  = 4'd5;
    localparam logic [CODE_W-1:0] CODE_PWRFAIL   = 4'd6;
    localparam logic [CODE_W-1:0] CODE_FAILWAIT  = 4'd7;
    localparam logic [CODE_W-1:0] CODE_ERROR     = 4'd8;
    localparam logic [CODE_W-1:0] CODE_OFF       = 4'd9;

    typedef struct packed {
        logic [TICK_W-1:0] now_tick;
        logic              power_req;
        logic              input_normal;
        logic              input_critical;
        logic              critical_ok;
        logic              critical_failure;
        logic              monitor_reading;
        logic [1:0]        thermal_level;
    } t_poll;

    typedef struct packed {
        logic [CODE_W-1:0] power_state;
        logic [1:0]        switch_command;
        logic              ramp_active;
        logic              read_sensors;
        logic              clear_minmax;
        logic              clear_thermal;
        logic              init_monitor;
        logic              status_logging;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] init_timeout;
        logic [CFG_W-1:0] ramp_timeout;
        logic [CFG_W-1:0] powerfail_delay;
        logic [CFG_W-1:0] error_delay;
        logic [CFG_W-1:0] read_interval_ramp;
        logic [CFG_W-1:0] read_interval_run;
    } t_cfg;

    // Updated state and the result for one poll
    typedef struct packed {
        t_state            state;
        logic [TICK_W-1:0] entry_tick;
        logic [TICK_W-1:0] last_read_tick;
        t_result           result;
    } t_step;

    function automatic logic [CODE_W-1:0] state_code(input t_state s);
        logic [CODE_W-1:0] c;
        c = CODE_INIT;
        unique case (s)
            ST_INIT:      c = CODE_INIT;
            ST_WAITINPUT: c = CODE_WAITINPUT;
            ST_STANDBY:   c = CODE_STANDBY;
            ST_RAMP:      c = CODE_RAMP;
            ST_RUN:       c = CODE_RUN;
            ST_OVERHEAT:  c = CODE_OVERHEAT;
            ST_PWRFAIL:   c = CODE_PWRFAIL;
            ST_FAILWAIT:  c = CODE_FAILWAIT;
            ST_ERROR:     c = CODE_ERROR;
            ST_OFF:       c = CODE_OFF;
            default:      c = CODE_INIT;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pwrseq_if.sv
// Valid/ready channel interfaces for polls and results of the power sequencer.
// Depends on pwrseq_pkg for the payload types.
`default_nettype none

interface pwrseq_poll_if;
    logic                 valid;
    logic                 ready;
    pwrseq_pkg::t_poll    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pwrseq_result_if;
    logic                 valid;
    logic                 ready;
    pwrseq_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pwrseq_step.sv
// Next-state and result logic for one poll of the power sequencer.
// Purely combinational; depends on pwrseq_pkg.
`default_nettype none

module pwrseq_step (
    input  var pwrseq_pkg::t_state                  i_state,
    input  var logic [pwrseq_pkg::TICK_W-1:0]       i_entry_tick,
    input  var logic [pwrseq_pkg::TICK_W-1:0]       i_last_read_tick,
    input  var pwrseq_pkg::t_cfg                    i_cfg,
    input  var pwrseq_pkg::t_poll                   i_poll,
    output pwrseq_pkg::t_step                       o_step
);

    logic                            forced;
    pwrseq_pkg::t_state              case_state;
    pwrseq_pkg::t_state              fin_state;
    logic [pwrseq_pkg::CFG_W-1:0]    limit;
    logic [pwrseq_pkg::TICK_W-1:0]   entry_diff;
    logic [pwrseq_pkg::TICK_W-1:0]   read_diff;
    logic [pwrseq_pkg::CFG_W-1:0]    interval;
    logic                            expired;
    logic                            do_read;
    logic                            enable;
    pwrseq_pkg::t_switch             sw;
    logic                            clr_thermal;
    logic                            init_mon;

    assign enable = i_poll.power_req;

    // Overheat preempts whatever state we are in
    assign forced     = (i_poll.thermal_level == pwrseq_pkg::THERMAL_SHUTDOWN)
                        && (i_state != pwrseq_pkg::ST_OVERHEAT);
    assign case_state = (i_poll.thermal_level == pwrseq_pkg::THERMAL_SHUTDOWN)
                        ? pwrseq_pkg::ST_OVERHEAT : i_state;

    // Only one timed state is active, so share a single subtract-compare
    always_comb begin
        limit = i_cfg.error_delay;
        unique case (case_state)
            pwrseq_pkg::ST_WAITINPUT: limit = i_cfg.init_timeout;
            pwrseq_pkg::ST_RAMP:      limit = i_cfg.ramp_timeout;
            pwrseq_pkg::ST_FAILWAIT:  limit = i_cfg.powerfail_delay;
            default:                  limit = i_cfg.error_delay;
        endcase
    end

    assign entry_diff = i_poll.now_tick - i_entry_tick;
    assign expired    = entry_diff > {{(pwrseq_pkg::TICK_W-pwrseq_pkg::CFG_W){1'b0}}, limit};

    always_comb begin
        fin_state   = case_state;
        sw          = pwrseq_pkg::SW_KEEP;
        clr_thermal = 1'b0;
        init_mon    = 1'b0;
        unique case (case_state)
            pwrseq_pkg::ST_INIT: begin
                init_mon = 1'b1;
                if (enable) begin
                    sw        = pwrseq_pkg::SW_ON;
                    fin_state = pwrseq_pkg::ST_WAITINPUT;
                end else begin
                    fin_state = pwrseq_pkg::ST_OFF;
                end
            end
            pwrseq_pkg::ST_WAITINPUT: begin
                priority if (!enable) fin_state = pwrseq_pkg::ST_OFF;
                else if (i_poll.input_normal || i_poll.critical_ok)
                    fin_state = pwrseq_pkg::ST_RAMP;
                else if (expired) fin_state = pwrseq_pkg::ST_OFF;
            end
            pwrseq_pkg::ST_STANDBY: begin
                if (enable && i_poll.input_normal) begin
                    sw        = pwrseq_pkg::SW_ON;
                    fin_state = pwrseq_pkg::ST_RAMP;
                end
            end
            pwrseq_pkg::ST_RAMP: begin
                // Rails ready resets the entry tick, so the timeout cannot fire after it
                priority if (!enable) fin_state = pwrseq_pkg::ST_OFF;
                else if (i_poll.critical_ok) fin_state = pwrseq_pkg::ST_RUN;
                else if (expired) fin_state = pwrseq_pkg::ST_PWRFAIL;
            end
            pwrseq_pkg::ST_RUN: begin
                priority if (!enable) fin_state = pwrseq_pkg::ST_OFF;
                else if (i_poll.input_critical) fin_state = pwrseq_pkg::ST_OFF;
                else if (i_poll.critical_failure) fin_state = pwrseq_pkg::ST_PWRFAIL;
                else if (!i_poll.monitor_reading) fin_state = pwrseq_pkg::ST_ERROR;
            end
            pwrseq_pkg::ST_OVERHEAT: begin
                priority if (!enable) begin
                    clr_thermal = 1'b1;
                    fin_state   = pwrseq_pkg::ST_OFF;
                end else if (i_poll.thermal_level == pwrseq_pkg::THERMAL_COOL) begin
                    fin_state = pwrseq_pkg::ST_STANDBY;
                end
            end
            pwrseq_pkg::ST_PWRFAIL: begin
                sw        = pwrseq_pkg::SW_OFF;
                fin_state = pwrseq_pkg::ST_FAILWAIT;
            end
            pwrseq_pkg::ST_FAILWAIT: begin
                if (expired) fin_state = pwrseq_pkg::ST_STANDBY;
            end
            pwrseq_pkg::ST_ERROR: begin
                if (expired) fin_state = pwrseq_pkg::ST_OFF;
            end
            pwrseq_pkg::ST_OFF: begin
                sw        = pwrseq_pkg::SW_OFF;
                fin_state = pwrseq_pkg::ST_STANDBY;
            end
            default: begin
                fin_state = case_state;
            end
        endcase
    end

    // Sensor read cadence follows the final state
    assign interval  = (fin_state == pwrseq_pkg::ST_RAMP) ? i_cfg.read_interval_ramp
                                                          : i_cfg.read_interval_run;
    assign read_diff = i_poll.now_tick - i_last_read_tick;
    assign do_read   = read_diff > {{(pwrseq_pkg::TICK_W-pwrseq_pkg::CFG_W){1'b0}}, interval};

    always_comb begin
        o_step.state          = fin_state;
        // Any move, including a forced one, restamps the entry tick
        o_step.entry_tick     = (forced || (fin_state != case_state)) ? i_poll.now_tick
                                                                      : i_entry_tick;
        o_step.last_read_tick = do_read ? i_poll.now_tick : i_last_read_tick;
        o_step.result.power_state    = pwrseq_pkg::state_code(fin_state);
        o_step.result.switch_command = sw;
        o_step.result.ramp_active    = (fin_state == pwrseq_pkg::ST_RAMP);
        o_step.result.read_sensors   = do_read;
        o_step.result.clear_minmax   = !enable;
        o_step.result.clear_thermal  = clr_thermal;
        o_step.result.init_monitor   = init_mon;
        o_step.result.status_logging = (fin_state == pwrseq_pkg::ST_RAMP)
                                       || (fin_state == pwrseq_pkg::ST_RUN);
    end

endmodule

`default_nettype wire

// File: hw/rtl/power_sequencer_fsm_core.sv
// Board power sequencer: one poll in, one result out.
// Results are registered: a poll's result shows on the output in the next cycle.
// Throughput: one poll per cycle while results are taken; state update and both tick
// compares settle in one step-logic pass, and the output register frees when taken.
// Reset (synchronous, active low): state init, entry and last-read ticks zero,
// configuration registers at their default timeouts, output register empty.
`default_nettype none

module power_sequencer_fsm_core (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_cfg_we,
    input  var logic [2:0]                          i_cfg_idx,
    input  var logic [pwrseq_pkg::CFG_W-1:0]        i_cfg_data,
    pwrseq_poll_if.sink                             i_poll,
    pwrseq_result_if.source                         o_result
);

    pwrseq_pkg::t_cfg                    r_cfg;
    pwrseq_pkg::t_state                  r_state;
    logic [pwrseq_pkg::TICK_W-1:0]       r_entry_tick;
    logic [pwrseq_pkg::TICK_W-1:0]       r_last_read_tick;
    pwrseq_pkg::t_result                 r_res;
    logic                                r_res_valid;

    pwrseq_pkg::t_step                   n_step;
    logic                                poll_xfer;

    // Take a poll whenever the output register is empty or being drained this cycle
    assign i_poll.ready = !r_res_valid || o_result.ready;
    assign poll_xfer    = i_poll.valid && i_poll.ready;

    assign o_result.valid = r_res_valid;
    assign o_result.data  = r_res;

    // Configuration writes; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_timeout       <= pwrseq_pkg::INIT_TIMEOUT_RST;
            r_cfg.ramp_timeout       <= pwrseq_pkg::RAMP_TIMEOUT_RST;
            r_cfg.powerfail_delay    <= pwrseq_pkg::POWERFAIL_DELAY_RST;
            r_cfg.error_delay        <= pwrseq_pkg::ERROR_DELAY_RST;
            r_cfg.read_interval_ramp <= pwrseq_pkg::READ_INTERVAL_RAMP_RST;
            r_cfg.read_interval_run  <= pwrseq_pkg::READ_INTERVAL_RUN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwrseq_pkg::CFG_INIT_TIMEOUT:       r_cfg.init_timeout       <= i_cfg_data;
                pwrseq_pkg::CFG_RAMP_TIMEOUT:       r_cfg.ramp_timeout       <= i_cfg_data;
                pwrseq_pkg::CFG_POWERFAIL_DELAY:    r_cfg.powerfail_delay    <= i_cfg_data;
                pwrseq_pkg::CFG_ERROR_DELAY:        r_cfg.error_delay        <= i_cfg_data;
                pwrseq_pkg::CFG_READ_INTERVAL_RAMP: r_cfg.read_interval_ramp <= i_cfg_data;
                pwrseq_pkg::CFG_READ_INTERVAL_RUN:  r_cfg.read_interval_run  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Overheat preemption, state case, and sensor-read cadence for one poll
    pwrseq_step u_step (
        .i_state          (r_state),
        .i_entry_tick     (r_entry_tick),
        .i_last_read_tick (r_last_read_tick),
        .i_cfg            (r_cfg),
        .i_poll           (i_poll.data),
        .o_step           (n_step)
    );

    // Advance sequencer state on each poll transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= pwrseq_pkg::ST_INIT;
            r_entry_tick     <= '0;
            r_last_read_tick <= '0;
        end else if (poll_xfer) begin
            r_state          <= n_step.state;
            r_entry_tick     <= n_step.entry_tick;
            r_last_read_tick <= n_step.last_read_tick;
        end
    end

    // Output register: load on a poll transfer, drop when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (poll_xfer) begin
            r_res_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (poll_xfer) begin
            r_res <= n_step.result;
        end
    end

endmodule

`default_nettype wire
